[rtl/scpu_pkg.sv]
// shared types and constants for the sixteen bit cpu step block
// no dependencies

package scpu_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int NUM_REGS  = 32;

	localparam logic [4:0] OP_ADD = 5'd0;
	localparam logic [4:0] OP_SUB = 5'd1;
	localparam logic [4:0] OP_MUL = 5'd2;
	localparam logic [4:0] OP_DIV = 5'd3;
	localparam logic [4:0] OP_AND = 5'd4;
	localparam logic [4:0] OP_OR  = 5'd5;
	localparam logic [4:0] OP_XOR = 5'd6;
	localparam logic [4:0] OP_SHL = 5'd7;
	localparam logic [4:0] OP_LDB = 5'd10;
	localparam logic [4:0] OP_LDW = 5'd11;
	localparam logic [4:0] OP_STB = 5'd12;
	localparam logic [4:0] OP_STW = 5'd13;
	localparam logic [4:0] OP_JMP = 5'd20;
	localparam logic [4:0] OP_JZ  = 5'd21;
	localparam logic [4:0] OP_JNZ = 5'd22;
	localparam logic [4:0] OP_JC  = 5'd23;
	localparam logic [4:0] OP_JNC = 5'd24;
	localparam logic [4:0] OP_JN  = 5'd25;
	localparam logic [4:0] OP_JNN = 5'd26;
	localparam logic [4:0] OP_IN  = 5'd27;
	localparam logic [4:0] OP_OUT = 5'd28;
	localparam logic [4:0] OP_RND = 5'd29;
	localparam logic [4:0] OP_HLT = 5'd31;

	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_HALT     = 4'd1,
		ST_STOPPED  = 4'd2,
		ST_BADREG   = 4'd3,
		ST_DIVZERO  = 4'd4,
		ST_BADOP    = 4'd5,
		ST_BADFETCH = 4'd6,
		ST_EMPTY    = 4'd7,
		ST_LOADED   = 4'd8
	} stat_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD,
		S_CHECK,
		S_FETCH,
		S_DECODE,
		S_RDREG,
		S_EXEC,
		S_DIV,
		S_MEM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] res;
		logic        c;
	} alu_res_t;

	typedef struct packed {
		logic        done;
		logic [15:0] q;
		logic [15:0] r;
	} div_res_t;

endpackage

[rtl/sixteen_bit_cpu_step.sv]
// top level of the sixteen bit cpu step block: sequencer, register file, flags
// depends on scpu_pkg, scpu_mem, scpu_alu, scpu_div

// One word in gives one word out. After reset the byte memory is swept to zero, one byte
// a cycle, over all MEM_BYTES (65536) bytes before the first word is taken. A load makes
// four single byte writes into the memory port. A step makes four byte fetches and three
// register reads through single ports, then the alu step; loads and stores add byte
// accesses to the memory, and div and rnd go through the bit serial divider. A stopped
// machine or a fetch past the end answers straight from the check state, with no fetch.
// No new word is taken until the result is taken.

module sixteen_bit_cpu_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// load_addr[13:0], load_word[45:14], in_value[61:46], rand_value[77:62], zero fill
	input  logic [79:0] s_tdata,
	// cmd
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pc_now[15:0], flag_n[16], flag_z[17], flag_c[18], out_reg[23:19], out_value[39:24]
	output logic [39:0] m_tdata,
	// status[3:0], out_valid[4]
	output logic [4:0]  m_tuser
);

	scpu_pkg::state_t state_q, state_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [scpu_pkg::MEM_AW-1:0] clr_q, clr_d;

	logic        cmd_q;
	logic [13:0] laddr_q;
	logic [31:0] lword_q;
	logic [15:0] inv_q;
	logic [15:0] rnd_q;

	logic [15:0] pc_q;
	logic        n_q, z_q, c_q, stop_q;
	logic [7:0]  b_q [4];
	logic [15:0] u1_q, u2_q, rd_q;
	logic [7:0]  lo_q;
	logic        neg_q;

	logic [15:0] regs [scpu_pkg::NUM_REGS];
	logic [scpu_pkg::NUM_REGS-1:0] rv_q;
	logic [15:0] rf_q;
	logic        rfv_q;
	logic [15:0] rfval;
	logic [4:0]  ra;

	scpu_pkg::stat_t ost_q;
	logic        ovld_q;
	logic [4:0]  oreg_q;
	logic [15:0] oval_q;

	logic        acc_in;
	logic        m_we;
	logic [15:0] m_addr;
	logic [7:0]  m_wdata;
	logic [7:0]  m_rdata;

	logic        fin, cmt, set_stop;
	scpu_pkg::stat_t fin_st;
	logic [15:0] c_res, c_npc;
	logic        c_c, c_flags, c_wr, c_out;

	logic        div_start;
	logic [15:0] div_num, div_den;
	scpu_pkg::div_res_t div_res;
	scpu_pkg::alu_res_t alu_res;

	logic [4:0]  op, dest, src1;
	logic        imm;
	logic [15:0] s2raw;
	logic [15:0] lbase;
	logic [16:0] lend;
	logic        load_ok;
	logic [15:0] madr, madr1;
	logic        ok0, ok1;
	logic        take;
	logic [15:0] q_fix;
	logic [1:0]  bidx;

	assign acc_in   = s_tvalid && s_tready;
	assign s_tready = (state_q == scpu_pkg::S_IDLE);
	assign m_tvalid = (state_q == scpu_pkg::S_DONE);
	assign m_tdata  = {oval_q, oreg_q, c_q, z_q, n_q, pc_q};
	assign m_tuser  = {ovld_q, ost_q};

	assign op    = b_q[0][7:3];
	assign dest  = {b_q[0][2:0], b_q[1][7:6]};
	assign src1  = b_q[1][5:1];
	assign imm   = b_q[1][0];
	assign s2raw = {b_q[2], b_q[3]};
	assign rfval = rfv_q ? rf_q : 16'd0;
	assign bidx  = 2'(cnt_q - 3'd1);

	assign lbase   = {laddr_q, 2'b00};
	assign lend    = {1'b0, lbase} + 17'd4;
	assign load_ok = (lend <= 17'(scpu_pkg::MEM_BYTES));

	assign madr  = ((op == scpu_pkg::OP_STB || op == scpu_pkg::OP_STW) ? rd_q : u1_q) + u2_q;
	assign madr1 = madr + 16'd1;
	assign ok0   = ({1'b0, madr} < 17'(scpu_pkg::MEM_BYTES));
	assign ok1   = ({1'b0, madr1} < 17'(scpu_pkg::MEM_BYTES));
	assign q_fix = neg_q ? 16'(-div_res.q) : div_res.q;

	scpu_mem u_mem (
		.clk   (clk),
		.we    (m_we),
		.addr  (m_addr[scpu_pkg::MEM_AW-1:0]),
		.wdata (m_wdata),
		.rdata (m_rdata)
	);

	scpu_alu u_alu (
		.op  (op),
		.u1  (u1_q),
		.u2  (u2_q),
		.res (alu_res)
	);

	scpu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	always_comb begin
		unique case (op)
			scpu_pkg::OP_JZ:  take = z_q;
			scpu_pkg::OP_JNZ: take = !z_q;
			scpu_pkg::OP_JC:  take = c_q;
			scpu_pkg::OP_JNC: take = !c_q;
			scpu_pkg::OP_JN:  take = n_q;
			scpu_pkg::OP_JNN: take = !n_q;
			default:          take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scpu_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		clr_d     = clr_q;
		m_we      = 1'b0;
		m_addr    = pc_q + 16'(cnt_q);
		m_wdata   = 8'd0;
		ra        = src1;
		fin       = 1'b0;
		fin_st    = scpu_pkg::ST_OK;
		cmt       = 1'b0;
		set_stop  = 1'b0;
		c_res     = 16'd0;
		c_npc     = pc_q + 16'd4;
		c_c       = 1'b0;
		c_flags   = 1'b1;
		c_wr      = 1'b0;
		c_out     = 1'b0;
		div_start = 1'b0;
		div_num   = u1_q[15] ? 16'(-u1_q) : u1_q;
		div_den   = u2_q[15] ? 16'(-u2_q) : u2_q;

		unique case (state_q)
			scpu_pkg::S_CLEAR: begin
				m_we   = 1'b1;
				m_addr = 16'(clr_q);
				clr_d  = clr_q + 1'b1;
				if (clr_q == scpu_pkg::MEM_AW'(scpu_pkg::MEM_BYTES - 1)) begin
					state_d = scpu_pkg::S_IDLE;
				end
			end
			scpu_pkg::S_IDLE: begin
				cnt_d = 3'd0;
				if (acc_in) begin
					state_d = s_tuser ? scpu_pkg::S_CHECK : scpu_pkg::S_LOAD;
				end
			end
			scpu_pkg::S_LOAD: begin
				m_we   = load_ok;
				m_addr = lbase + 16'(cnt_q);
				case (cnt_q[1:0])
					2'd0:    m_wdata = lword_q[31:24];
					2'd1:    m_wdata = lword_q[23:16];
					2'd2:    m_wdata = lword_q[15:8];
					default: m_wdata = lword_q[7:0];
				endcase
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd3) begin
					fin    = 1'b1;
					fin_st = scpu_pkg::ST_LOADED;
				end
			end
			scpu_pkg::S_CHECK: begin
				cnt_d = 3'd0;
				if (stop_q) begin
					fin    = 1'b1;
					fin_st = scpu_pkg::ST_STOPPED;
				end else if ({1'b0, pc_q} + 17'd3 >= 17'(scpu_pkg::MEM_BYTES)) begin
					fin    = 1'b1;
					fin_st = scpu_pkg::ST_BADFETCH;
				end else begin
					state_d = scpu_pkg::S_FETCH;
				end
			end
			scpu_pkg::S_FETCH: begin
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					state_d = scpu_pkg::S_DECODE;
				end
			end
			scpu_pkg::S_DECODE: begin
				cnt_d = 3'd0;
				if (!imm && s2raw[15:5] != 11'd0) begin
					fin      = 1'b1;
					fin_st   = scpu_pkg::ST_BADREG;
					set_stop = 1'b1;
				end else begin
					state_d = scpu_pkg::S_RDREG;
				end
			end
			scpu_pkg::S_RDREG: begin
				case (cnt_q[1:0])
					2'd0:    ra = src1;
					2'd1:    ra = s2raw[4:0];
					default: ra = dest;
				endcase
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd3) begin
					state_d = scpu_pkg::S_EXEC;
				end
			end
			scpu_pkg::S_EXEC: begin
				cnt_d = 3'd0;
				unique case (op) inside
					scpu_pkg::OP_ADD, scpu_pkg::OP_SUB, scpu_pkg::OP_MUL, scpu_pkg::OP_AND,
					scpu_pkg::OP_OR, scpu_pkg::OP_XOR, scpu_pkg::OP_SHL: begin
						cmt   = 1'b1;
						c_res = alu_res.res;
						c_c   = alu_res.c;
						c_wr  = 1'b1;
					end
					scpu_pkg::OP_DIV: begin
						if (u2_q == 16'd0) begin
							set_stop = 1'b1;
							fin_st   = scpu_pkg::ST_DIVZERO;
						end else begin
							div_start = 1'b1;
							state_d   = scpu_pkg::S_DIV;
						end
					end
					scpu_pkg::OP_LDB, scpu_pkg::OP_LDW, scpu_pkg::OP_STB,
					scpu_pkg::OP_STW: begin
						state_d = scpu_pkg::S_MEM;
					end
					scpu_pkg::OP_JMP, scpu_pkg::OP_JZ, scpu_pkg::OP_JNZ, scpu_pkg::OP_JC,
					scpu_pkg::OP_JNC, scpu_pkg::OP_JN, scpu_pkg::OP_JNN: begin
						cmt     = 1'b1;
						c_c     = c_q;
						c_flags = 1'b0;
						if (take) begin
							c_npc = u2_q;
						end
					end
					scpu_pkg::OP_IN: begin
						cmt   = 1'b1;
						c_res = inv_q;
						c_wr  = 1'b1;
					end
					scpu_pkg::OP_OUT: begin
						cmt   = 1'b1;
						c_res = rd_q;
						c_out = 1'b1;
					end
					scpu_pkg::OP_RND: begin
						if ($signed(u1_q) >= $signed(u2_q)) begin
							set_stop = 1'b1;
							fin_st   = scpu_pkg::ST_EMPTY;
						end else begin
							div_start = 1'b1;
							div_num   = rnd_q;
							div_den   = u2_q - u1_q;
							state_d   = scpu_pkg::S_DIV;
						end
					end
					scpu_pkg::OP_HLT: begin
						cmt      = 1'b1;
						c_npc    = pc_q;
						c_c      = c_q;
						c_flags  = 1'b0;
						fin_st   = scpu_pkg::ST_HALT;
						set_stop = 1'b1;
					end
					default: begin
						set_stop = 1'b1;
						fin_st   = scpu_pkg::ST_BADOP;
					end
				endcase
				if (state_d == scpu_pkg::S_EXEC) begin
					fin = 1'b1;
				end
			end
			scpu_pkg::S_DIV: begin
				if (div_res.done) begin
					fin   = 1'b1;
					cmt   = 1'b1;
					c_wr  = 1'b1;
					c_res = (op == scpu_pkg::OP_DIV) ? q_fix : u1_q + div_res.r;
				end
			end
			scpu_pkg::S_MEM: begin
				cnt_d  = cnt_q + 3'd1;
				m_addr = (cnt_q == 3'd0) ? madr : madr1;
				unique case (op)
					scpu_pkg::OP_STB: begin
						m_we    = ok0;
						m_wdata = u1_q[7:0];
						fin     = 1'b1;
						cmt     = 1'b1;
						c_res   = {8'd0, u1_q[7:0]};
					end
					scpu_pkg::OP_STW: begin
						if (cnt_q == 3'd0) begin
							m_we    = ok0;
							m_wdata = u1_q[7:0];
						end else begin
							m_we    = ok1;
							m_wdata = u1_q[15:8];
							fin     = 1'b1;
							cmt     = 1'b1;
							c_res   = u1_q;
						end
					end
					scpu_pkg::OP_LDB: begin
						if (cnt_q == 3'd1) begin
							fin   = 1'b1;
							cmt   = 1'b1;
							c_wr  = 1'b1;
							c_res = ok0 ? {{8{m_rdata[7]}}, m_rdata} : 16'd0;
						end
					end
					default: begin
						if (cnt_q == 3'd2) begin
							fin   = 1'b1;
							cmt   = 1'b1;
							c_wr  = 1'b1;
							c_res = {ok1 ? m_rdata : 8'd0, lo_q};
						end
					end
				endcase
			end
			scpu_pkg::S_DONE: begin
				if (m_tready) begin
					state_d = scpu_pkg::S_IDLE;
				end
			end
			default: state_d = scpu_pkg::S_IDLE;
		endcase

		if (fin) begin
			state_d = scpu_pkg::S_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			clr_q  <= '0;
			pc_q   <= '0;
			n_q    <= 1'b0;
			z_q    <= 1'b0;
			c_q    <= 1'b0;
			stop_q <= 1'b0;
			rv_q   <= '0;
		end else begin
			cnt_q <= cnt_d;
			clr_q <= clr_d;
			if (cmt) begin
				pc_q <= c_npc;
				c_q  <= c_c;
				if (c_flags) begin
					z_q <= (c_res == 16'd0);
					n_q <= c_res[15];
				end
				if (c_wr && dest != 5'd0) begin
					rv_q[dest] <= 1'b1;
				end
			end
			if (set_stop) begin
				stop_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			cmd_q   <= s_tuser;
			laddr_q <= s_tdata[13:0];
			lword_q <= s_tdata[45:14];
			inv_q   <= s_tdata[61:46];
			rnd_q   <= s_tdata[77:62];
		end
		if (state_q == scpu_pkg::S_FETCH && cnt_q != 3'd0) begin
			b_q[bidx] <= m_rdata;
		end
		if (state_q == scpu_pkg::S_RDREG) begin
			case (cnt_q[1:0])
				2'd1:    u1_q <= rfval;
				2'd2:    u2_q <= imm ? s2raw : rfval;
				2'd3:    rd_q <= rfval;
				default: ;
			endcase
		end
		if (state_q == scpu_pkg::S_MEM && cnt_q == 3'd1) begin
			lo_q <= ok0 ? m_rdata : 8'd0;
		end
		if (div_start) begin
			neg_q <= u1_q[15] ^ u2_q[15];
		end
		rf_q  <= regs[ra];
		rfv_q <= rv_q[ra];
		if (cmt && c_wr && dest != 5'd0) begin
			regs[dest] <= c_res;
		end
		if (fin) begin
			ost_q  <= fin_st;
			ovld_q <= c_out && cmd_q;
			oreg_q <= c_out ? dest : 5'd0;
			oval_q <= c_out ? rd_q : 16'd0;
		end
	end

endmodule

[rtl/scpu_mem.sv]
// byte wide single port ram with registered read data
// depends on scpu_pkg

module scpu_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [scpu_pkg::MEM_AW-1:0] addr,
	input  logic [7:0]                 wdata,
	output logic [7:0]                 rdata
);

	logic [7:0] mem [scpu_pkg::MEM_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/scpu_alu.sv]
// combinational alu: add, sub, byte mul, logic ops and shift with carry
// depends on scpu_pkg

module scpu_alu (
	input  logic [4:0]         op,
	input  logic [15:0]        u1,
	input  logic [15:0]        u2,
	output scpu_pkg::alu_res_t res
);

	logic [16:0] sum;
	logic [31:0] lsh;
	logic [16:0] rsh;
	logic [15:0] neg2;

	always_comb begin
		sum  = {1'b0, u1} + {1'b0, u2};
		neg2 = 16'(-u2);
		lsh  = {16'b0, u1} << u2[4:0];
		rsh  = {u1, 1'b0} >> neg2[4:0];
		res  = '0;
		case (op)
			scpu_pkg::OP_ADD: begin
				res.res = sum[15:0];
				res.c   = sum[16];
			end
			scpu_pkg::OP_SUB: begin
				res.res = u1 - u2;
				res.c   = sum[16];
			end
			scpu_pkg::OP_MUL: res.res = u1[7:0] * u2[7:0];
			scpu_pkg::OP_AND: res.res = u1 & u2;
			scpu_pkg::OP_OR:  res.res = u1 | u2;
			scpu_pkg::OP_XOR: res.res = u1 ^ u2;
			scpu_pkg::OP_SHL: begin
				if ($signed(u2) > 16'sd16 || $signed(u2) < -16'sd16) begin
					res = '0;
				end else if ($signed(u2) > 16'sd0) begin
					res.res = lsh[15:0];
					res.c   = lsh[16];
				end else if ($signed(u2) < 16'sd0) begin
					res.res = rsh[16:1];
					res.c   = rsh[0];
				end else begin
					res.res = u1;
				end
			end
			default: res = '0;
		endcase
	end

endmodule

[rtl/scpu_div.sv]
// iterative unsigned 16 bit divider, one quotient bit per cycle
// depends on scpu_pkg

module scpu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        num,
	input  logic [15:0]        den,
	output scpu_pkg::div_res_t res
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] den_q;
	logic [16:0] trial;

	assign trial = {rem_q, quo_q[15]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
			end else begin
				rem_q <= {rem_q[14:0], quo_q[15]};
			end
			quo_q <= {quo_q[14:0], ~trial[16]};
		end
	end

	assign res.done = done_q;
	assign res.q    = quo_q;
	assign res.r    = rem_q;

endmodule

[rtl/scpu_chk.sv]
// port level checker for sixteen_bit_cpu_step, bound to the top level
// depends on sixteen_bit_cpu_step ports only

module scpu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [79:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [4:0]  m_tuser
);

	// one word in flight at a time
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid)
		else $error("accept not followed by busy cycle");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("result repeated");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind sixteen_bit_cpu_step scpu_chk u_chk (.*);
